// ----- rtl/skyl_pkg.sv -----
// Shared types and constants of the skyline rectangle allocator.
package skyl_pkg;

  localparam int CMD_W = 1;
  localparam int BLK_W = 8;
  localparam int POS_W = 7;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_LOAD,
    DP_CLEAR,
    DP_SUFFIX,
    DP_SCAN,
    DP_FILL,
    DP_PUT
  } dp_op_t;

  typedef enum logic [1:0] {
    RES_FAIL,
    RES_PLACED,
    RES_CLEARED
  } res_kind_t;

  typedef struct packed {
    dp_op_t    op;
    res_kind_t res;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic bad_width;
    logic pass_end;
    logic fill_end;
    logic fits;
  } dp_sts_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_SUFFIX,
    ST_SCAN,
    ST_CHECK,
    ST_FILL,
    ST_RESULT
  } skyl_state_t;

endpackage

// ----- rtl/skyl_if.sv -----
// Request and result channel interfaces of the skyline rectangle allocator.
interface skyl_in_if;
  logic                        valid;
  logic                        ready;
  logic [skyl_pkg::CMD_W-1:0]  cmd;
  logic [skyl_pkg::BLK_W-1:0]  block_width;
  logic [skyl_pkg::BLK_W-1:0]  block_height;

  modport source (output valid, cmd, block_width, block_height, input ready);
  modport sink (input valid, cmd, block_width, block_height, output ready);
endinterface

interface skyl_out_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [skyl_pkg::POS_W-1:0]  pos_x;
  logic [skyl_pkg::POS_W-1:0]  pos_y;

  modport source (output valid, ok, pos_x, pos_y, input ready);
  modport sink (input valid, ok, pos_x, pos_y, output ready);
endinterface

// ----- rtl/skyl_ctrl.sv -----
// Sequencing state machine of the skyline rectangle allocator.
module skyl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  skyl_pkg::dp_sts_t sts,
  output skyl_pkg::dp_cmd_t cmd
);
  import skyl_pkg::*;

  skyl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;
  res_kind_t   res_kind;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    if (sts.is_clear) begin
      res_kind = RES_CLEARED;
    end else if (sts.fits) begin
      res_kind = RES_PLACED;
    end else begin
      res_kind = RES_FAIL;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (sts.pass_end) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts.is_clear) begin
          state_nxt = ST_CLEAR;
        end else if (sts.bad_width) begin
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_SUFFIX;
        end
      end
      ST_CLEAR: begin
        if (sts.pass_end) state_nxt = ST_RESULT;
      end
      ST_SUFFIX: begin
        if (sts.pass_end) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.pass_end) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = sts.fits ? ST_FILL : ST_RESULT;
      end
      ST_FILL: begin
        if (sts.fill_end) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd.op        = DP_IDLE;
    cmd.res       = res_kind;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_INIT:   cmd.op = DP_CLEAR;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = DP_LOAD;
      end
      ST_CLEAR:  cmd.op = DP_CLEAR;
      ST_SUFFIX: cmd.op = DP_SUFFIX;
      ST_SCAN:   cmd.op = DP_SCAN;
      ST_FILL:   cmd.op = DP_FILL;
      ST_RESULT: begin
        if (slot_free) begin
          cmd.op        = DP_PUT;
          out_valid_nxt = 1'b1;
        end
      end
      default:   cmd.op = DP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/skyl_dp.sv -----
// Skyline store, window-maximum scan and fill datapath of the allocator.
module skyl_dp #(
  parameter int ATLAS_COLUMNS = 128,
  parameter int ATLAS_ROWS    = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  skyl_pkg::dp_cmd_t           cmd,
  output skyl_pkg::dp_sts_t           sts,
  input  logic [skyl_pkg::CMD_W-1:0]  in_cmd,
  input  logic [skyl_pkg::BLK_W-1:0]  in_block_width,
  input  logic [skyl_pkg::BLK_W-1:0]  in_block_height,
  output logic                        out_ok,
  output logic [skyl_pkg::POS_W-1:0]  out_pos_x,
  output logic [skyl_pkg::POS_W-1:0]  out_pos_y
);
  import skyl_pkg::*;

  localparam int CW    = $clog2(ATLAS_COLUMNS);
  localparam int CNT_W = $clog2(ATLAS_COLUMNS + 1);
  localparam int HW    = $clog2(ATLAS_ROWS + 1);
  localparam int CMP_W = ((CNT_W > BLK_W) ? CNT_W : BLK_W) + 1;
  localparam int SUM_W = ((HW > BLK_W) ? HW : BLK_W) + 1;

  logic [HW-1:0]    col_mem [ATLAS_COLUMNS];
  logic [HW-1:0]    suf_mem [ATLAS_COLUMNS];

  logic [CMD_W-1:0] cmd_r;
  logic [BLK_W-1:0] w_r, h_r, k_r;
  logic [CNT_W-1:0] cnt_r;
  logic             p_vld_r, p_scan_r, p_bs_r, p_win_r;
  logic [CW-1:0]    p_idx_r;
  logic [HW-1:0]    run_r, best_top_r, col_rd_r, suf_rd_r;
  logic [CW-1:0]    best_x_r;
  logic             ok_r;
  logic [POS_W-1:0] pos_x_r, pos_y_r;

  logic [BLK_W-1:0] w_m1, k_up, k_dn;
  logic [CMP_W-1:0] cnt_cmp, wm1_cmp;
  logic             pass_end, issue, in_win;
  logic [CW-1:0]    rev_idx, fwd_idx, start_idx, col_raddr, fill_addr;
  logic [SUM_W-1:0] top_sum;
  logic [HW-1:0]    run_new, win_max;
  logic             col_we, suf_we, improve;
  logic [CW-1:0]    col_waddr;
  logic [HW-1:0]    col_wdata;

  assign w_m1      = w_r - BLK_W'(1);
  assign k_up      = (k_r == w_m1) ? '0 : k_r + BLK_W'(1);
  assign k_dn      = (k_r == '0) ? w_m1 : k_r - BLK_W'(1);
  assign cnt_cmp   = CMP_W'(cnt_r);
  assign wm1_cmp   = CMP_W'(w_m1);
  assign pass_end  = (cnt_r == CNT_W'(ATLAS_COLUMNS));
  assign issue     = ((cmd.op == DP_SUFFIX) || (cmd.op == DP_SCAN)) && !pass_end;
  assign in_win    = (cnt_cmp >= wm1_cmp);
  assign rev_idx   = CW'(CNT_W'(ATLAS_COLUMNS - 1) - cnt_r);
  assign fwd_idx   = CW'(cnt_r);
  assign start_idx = CW'(cnt_cmp - wm1_cmp);
  assign col_raddr = (cmd.op == DP_SUFFIX) ? rev_idx : fwd_idx;
  assign fill_addr = CW'(CMP_W'(best_x_r) + cnt_cmp);
  assign top_sum   = SUM_W'(best_top_r) + SUM_W'(h_r);

  assign run_new   = (p_bs_r || col_rd_r > run_r) ? col_rd_r : run_r;
  assign win_max   = (suf_rd_r > run_new) ? suf_rd_r : run_new;
  assign suf_we    = p_vld_r && !p_scan_r;
  assign improve   = p_vld_r && p_scan_r && p_win_r && (win_max < best_top_r);

  always_comb begin
    col_we    = 1'b0;
    col_waddr = fwd_idx;
    col_wdata = '0;
    if (cmd.op == DP_CLEAR && !pass_end) begin
      col_we = 1'b1;
    end else if (cmd.op == DP_FILL) begin
      col_we    = 1'b1;
      col_waddr = fill_addr;
      col_wdata = HW'(top_sum);
    end
  end

  assign sts.is_clear  = cmd_r[0];
  assign sts.bad_width = (w_r == '0) || (CMP_W'(w_r) > CMP_W'(ATLAS_COLUMNS));
  assign sts.pass_end  = pass_end;
  assign sts.fill_end  = (cnt_cmp == wm1_cmp);
  assign sts.fits      = (best_top_r < HW'(ATLAS_ROWS)) &&
                         (top_sum <= SUM_W'(ATLAS_ROWS));

  always_ff @(posedge clk) begin
    if (col_we) col_mem[col_waddr] <= col_wdata;
    col_rd_r <= col_mem[col_raddr];
    if (suf_we) suf_mem[p_idx_r] <= run_new;
    suf_rd_r <= suf_mem[start_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= issue;
      case (cmd.op) inside
        DP_LOAD:                     cnt_r <= '0;
        DP_CLEAR, DP_SUFFIX, DP_SCAN: cnt_r <= pass_end ? '0 : cnt_r + CNT_W'(1);
        DP_FILL:                     cnt_r <= cnt_r + CNT_W'(1);
        default:                     cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      cmd_r      <= in_cmd;
      w_r        <= in_block_width;
      h_r        <= in_block_height;
      k_r        <= '0;
      best_top_r <= HW'(ATLAS_ROWS);
      best_x_r   <= '0;
    end else begin
      if (issue) begin
        k_r <= (cmd.op == DP_SCAN) ? k_dn : k_up;
      end
      if (improve) begin
        best_top_r <= win_max;
        best_x_r   <= p_idx_r;
      end
    end
    p_scan_r <= (cmd.op == DP_SCAN);
    p_bs_r   <= (k_r == '0) || ((cmd.op == DP_SCAN) && (cnt_r == '0));
    p_win_r  <= in_win;
    p_idx_r  <= (cmd.op == DP_SUFFIX) ? rev_idx : start_idx;
    if (p_vld_r) run_r <= run_new;
    if (cmd.op == DP_PUT) begin
      case (cmd.res)
        RES_PLACED: begin
          ok_r    <= 1'b1;
          pos_x_r <= POS_W'(best_x_r);
          pos_y_r <= POS_W'(best_top_r);
        end
        RES_CLEARED: begin
          ok_r    <= 1'b1;
          pos_x_r <= '0;
          pos_y_r <= '0;
        end
        default: begin
          ok_r    <= 1'b0;
          pos_x_r <= '0;
          pos_y_r <= '0;
        end
      endcase
    end
  end

  assign out_ok    = ok_r;
  assign out_pos_x = pos_x_r;
  assign out_pos_y = pos_y_r;

endmodule

// ----- rtl/skyline_rect_allocator_unit.sv -----
// Skyline bottom-left rectangle allocator, top level.
//
// Requests arrive on in_ch (valid/ready): cmd 0 allocates a block_width by
// block_height rectangle, cmd 1 clears every column of the skyline to zero.
// Each request yields one result on out_ch (valid/ready): ok, pos_x, pos_y.
// One request is in work at a time; in_ch.ready is high only while idle.
// An allocation makes one pass over the columns that builds block-wise
// suffix maxima, then a second pass that forms the window maximum of every
// start column and keeps the lowest, then writes the covered columns one
// per cycle. The column store has a single read and a single write port;
// a bad width skips the passes and a rectangle that does not fit skips the
// writes.
// After reset the column store is zeroed by a clearing pass, during which
// no request is accepted.
// The result sits in an output register; while out_ch stalls the finished
// result holds, and the next result waits until that register frees.
module skyline_rect_allocator_unit #(
  parameter int ATLAS_COLUMNS = 128,
  parameter int ATLAS_ROWS    = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  skyl_in_if.sink    in_ch,
  skyl_out_if.source out_ch
);
  import skyl_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  skyl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  skyl_dp #(
    .ATLAS_COLUMNS (ATLAS_COLUMNS),
    .ATLAS_ROWS    (ATLAS_ROWS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .sts             (dp_sts),
    .in_cmd          (in_ch.cmd),
    .in_block_width  (in_ch.block_width),
    .in_block_height (in_ch.block_height),
    .out_ok          (out_ch.ok),
    .out_pos_x       (out_ch.pos_x),
    .out_pos_y       (out_ch.pos_y)
  );

endmodule

// ----- rtl/skyl_chk.sv -----
// Port-level assertions of the skyline rectangle allocator and their binding.
module skyl_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_ok,
  input logic [skyl_pkg::POS_W-1:0] out_pos_x,
  input logic [skyl_pkg::POS_W-1:0] out_pos_y
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

  a_fail_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_pos_x == '0 && out_pos_y == '0)
    else $error("failed result carries a position");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken before the skyline is cleared");

endmodule

bind skyline_rect_allocator_unit skyl_chk u_skyl_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_ok    (out_ch.ok),
  .out_pos_x (out_ch.pos_x),
  .out_pos_y (out_ch.pos_y)
);

// ----- verif/skyl_placement_checker.sv -----
// Checker: predicts each placement from the accepted requests and compares the results.
module skyl_placement_checker #(
  parameter int ATLAS_COLUMNS = 128,
  parameter int ATLAS_ROWS    = 128
) (
  input  logic clk,
  input  logic rst_n,
  skyl_in_if   in_ch,
  skyl_out_if  out_ch,
  output int   mismatch_count,
  output int   results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import skyl_pkg::*;

  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } placement_t;

  int unsigned column_top [ATLAS_COLUMNS];
  placement_t  placements_due [$];

  function automatic placement_t place_block(logic is_clear, logic [BLK_W-1:0] w,
                                             logic [BLK_W-1:0] h);
    placement_t  r;
    int unsigned best_top;
    int unsigned best_x;
    int unsigned span_top;
    int unsigned s;
    int unsigned k;
    bit          found;
    bit          usable;
    r        = '0;
    best_top = ATLAS_ROWS;
    best_x   = 0;
    found    = 1'b0;
    if (is_clear) begin
      foreach (column_top[c]) column_top[c] = 0;
      r.ok = 1'b1;
      return r;
    end
    if (w == 0 || w > ATLAS_COLUMNS) return r;
    for (s = 0; s + w <= ATLAS_COLUMNS; s++) begin
      span_top = 0;
      usable   = 1'b1;
      for (k = 0; k < w; k++) begin
        if (column_top[s + k] >= best_top) usable = 1'b0;
        if (column_top[s + k] > span_top) span_top = column_top[s + k];
      end
      if (usable) begin
        found    = 1'b1;
        best_top = span_top;
        best_x   = s;
      end
    end
    if (!found || best_top + h > ATLAS_ROWS) return r;
    for (k = 0; k < w; k++) column_top[best_x + k] = best_top + h;
    r.ok    = 1'b1;
    r.pos_x = best_x[POS_W-1:0];
    r.pos_y = best_top[POS_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    placement_t want;
    bit         bad;
    if (!rst_n) begin
      foreach (column_top[c]) column_top[c] = 0;
      placements_due.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        placements_due.push_back(place_block(in_ch.cmd[0], in_ch.block_width,
                                             in_ch.block_height));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (placements_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result ok=%0d pos_x=%0d pos_y=%0d", $time,
                   out_ch.ok, out_ch.pos_x, out_ch.pos_y);
        end else begin
          want = placements_due.pop_front();
          bad  = 1'b0;
          if (out_ch.ok !== want.ok) begin
            bad = 1'b1;
            $display("%0t: ok expected %0d, got %0d", $time, want.ok, out_ch.ok);
          end
          if (out_ch.pos_x !== want.pos_x) begin
            bad = 1'b1;
            $display("%0t: pos_x expected %0d, got %0d", $time, want.pos_x, out_ch.pos_x);
          end
          if (out_ch.pos_y !== want.pos_y) begin
            bad = 1'b1;
            $display("%0t: pos_y expected %0d, got %0d", $time, want.pos_y, out_ch.pos_y);
          end
          if (bad) mismatch_count++;
        end
      end
    end
    results_due = placements_due.size();
  end

endmodule

// ----- verif/testbench.sv -----
// Testbench top: clock, reset, request stimulus, result stalls and the final verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import skyl_pkg::*;

  localparam int COLS = 128;
  localparam int ROWS = 128;
  localparam int RANDOM_REQUESTS = 750;
  localparam int CALM_FROM = 650;
  localparam int TAIL_CYCLES = 600;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatch_count;
  int   results_due;
  bit   calm;
  bit   tx_bursty;
  bit   rx_bursty;

  skyl_in_if  in_ch();
  skyl_out_if out_ch();

  skyline_rect_allocator_unit #(
    .ATLAS_COLUMNS(COLS),
    .ATLAS_ROWS   (ROWS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  skyl_placement_checker #(
    .ATLAS_COLUMNS(COLS),
    .ATLAS_ROWS   (ROWS)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatch_count(mismatch_count),
    .results_due   (results_due)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // stall the result channel in bursts
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) rx_bursty = !rx_bursty;
      if (!calm && rx_bursty && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    if (calm || !tx_bursty || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, 14);
  endfunction

  task automatic send_request(input logic is_clear, input logic [BLK_W-1:0] w,
                              input logic [BLK_W-1:0] h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= is_clear;
    in_ch.block_width  <= w;
    in_ch.block_height <= h;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  initial begin
    int              i;
    int              roll;
    int              guard;
    logic [BLK_W-1:0] w;
    logic [BLK_W-1:0] h;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.cmd          <= 1'b0;
    in_ch.block_width  <= '0;
    in_ch.block_height <= '0;
    calm      = 1'b0;
    tx_bursty = 1'b1;
    rx_bursty = 1'b1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: edges of the fields, full columns, zero sizes, clears
    send_request(1'b0, 8'd1, 8'd1);
    send_request(1'b0, 8'd128, 8'd1);
    send_request(1'b0, 8'd0, 8'd5);
    send_request(1'b0, 8'd129, 8'd1);
    send_request(1'b0, 8'd255, 8'd255);
    send_request(1'b0, 8'd4, 8'd0);
    send_request(1'b0, 8'd3, 8'd255);
    send_request(1'b0, 8'd2, 8'd126);
    send_request(1'b0, 8'd128, 8'd0);
    send_request(1'b0, 8'd126, 8'd126);
    send_request(1'b0, 8'd1, 8'd1);
    send_request(1'b0, 8'd1, 8'd0);
    send_request(1'b1, 8'd255, 8'd255);
    send_request(1'b0, 8'd128, 8'd128);
    send_request(1'b1, 8'd0, 8'd0);
    send_request(1'b0, 8'd1, 8'd128);
    send_request(1'b0, 8'd127, 8'd127);
    send_request(1'b0, 8'd1, 8'd1);
    send_request(1'b0, 8'd128, 8'd1);
    send_request(1'b1, 8'd7, 8'd9);
    send_request(1'b0, 8'd64, 8'd64);
    send_request(1'b0, 8'd65, 8'd64);
    send_request(1'b0, 8'd63, 8'd129);
    wait_drained();

    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      calm = (i >= CALM_FROM);
      if (i % 50 == 0) tx_bursty = ($urandom_range(0, 2) != 0);
      if (!calm && i % 150 == 75) wait_drained();
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send_request(1'b1, BLK_W'($urandom_range(0, 255)),
                     BLK_W'($urandom_range(0, 255)));
      end else if (roll < 10) begin
        case ($urandom_range(0, 2))
          0: w = 8'd0;
          1: w = BLK_W'($urandom_range(129, 255));
          default: w = BLK_W'($urandom_range(0, 255));
        endcase
        send_request(1'b0, w, BLK_W'($urandom_range(0, 255)));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) w = BLK_W'($urandom_range(1, 16));
        else if (roll < 90) w = BLK_W'($urandom_range(1, 64));
        else w = BLK_W'($urandom_range(1, 128));
        roll = $urandom_range(0, 99);
        if (roll < 70) h = BLK_W'($urandom_range(1, 16));
        else if (roll < 90) h = BLK_W'($urandom_range(1, 64));
        else if (roll < 95) h = 8'd0;
        else h = BLK_W'($urandom_range(65, 128));
        send_request(1'b0, w, h);
      end
    end
    in_ch.valid <= 1'b0;

    guard = 0;
    while (results_due != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/skyl_pkg.sv
rtl/skyl_if.sv
rtl/skyl_ctrl.sv
rtl/skyl_dp.sv
rtl/skyline_rect_allocator_unit.sv
rtl/skyl_chk.sv
verif/skyl_placement_checker.sv
verif/testbench.sv
